FILE: src/bounded_double_ended_queue_defines.svh
// Assertion macros shared by the double-ended queue RTL.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bdq_pkg.sv
// Types and constants for the bounded double-ended queue.
package bdq_pkg;

  localparam int DATA_W        = 32;
  localparam int OP_W          = 3;
  localparam int CAP_W         = 5;
  localparam int DEPTH_DEFAULT = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_REAR  = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_REAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY     = 3'd4;

  // Value reported for the front and rear items of an empty queue.
  localparam logic signed [DATA_W-1:0] EMPTY_ITEM = -32'sd1;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic                     success;
    logic signed [DATA_W-1:0] front_item;
    logic signed [DATA_W-1:0] rear_item;
    logic                     is_empty;
    logic                     is_full;
  } out_word_t;

endpackage

FILE: src/bounded_double_ended_queue.sv
// A word accepted on the input updates the queue, both item reads of the ring
// memory are registered in S_READ, and S_RESP holds the result word until it is
// taken. The next word is taken only after the result is taken, since in_ready
// is high only in S_IDLE.
// Reset (rst_n, synchronous, active low) empties the queue and sets capacity
// to 16; the ring memory is not cleared.
`include "bounded_double_ended_queue_defines.svh"

module bounded_double_ended_queue #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  bdq_pkg::in_word_t        in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output bdq_pkg::out_word_t       out_data,
  input  logic                     cfg_we,
  input  logic [bdq_pkg::CAP_W-1:0] cfg_wdata
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > bdq_pkg::CAP_W) ? CNT_W : bdq_pkg::CAP_W;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(DEPTH);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  // Ring pointer helpers with wrap at DEPTH.
  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    wrap_inc = (p == IDX_LAST) ? '0 : p + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] p);
    wrap_dec = (p == '0) ? IDX_LAST : p - IDX_W'(1);
  endfunction

  logic [1:0]                       state_r, state_nxt;
  logic [IDX_W-1:0]                 head_r, head_nxt;
  logic [IDX_W-1:0]                 tail_r, tail_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic [bdq_pkg::CAP_W-1:0]        cap_r;
  logic                             ok_r, ok_nxt;
  logic                             full_r, full_nxt;
  logic                             empty_r;
  logic                             acc;
  logic                             full_now;
  logic                             empty_now;
  logic [CMP_W-1:0]                 cap_ext;
  logic [CMP_W-1:0]                 eff_cap;
  logic                             mem_we;
  logic [IDX_W-1:0]                 mem_wr_addr;
  logic signed [bdq_pkg::DATA_W-1:0] rd_front_r;
  logic signed [bdq_pkg::DATA_W-1:0] rd_rear_r;
  logic signed [bdq_pkg::DATA_W-1:0] ring_mem [DEPTH];

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_RESP);
  assign acc       = in_valid && in_ready;

  // Effective capacity is the register value limited to the built depth.
  always_comb begin
    cap_ext   = CMP_W'(cap_r);
    eff_cap   = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
    full_now  = CMP_W'(cnt_r) >= eff_cap;
    empty_now = (cnt_r == '0);
  end

  // Pointer and count update for the accepted word.
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    cnt_nxt     = cnt_r;
    ok_nxt      = 1'b0;
    mem_we      = 1'b0;
    mem_wr_addr = tail_r;
    case (in_data.opcode)
      bdq_pkg::OP_INS_FRONT: begin
        if (!full_now) begin
          head_nxt    = wrap_dec(head_r);
          mem_wr_addr = wrap_dec(head_r);
          mem_we      = acc;
          cnt_nxt     = cnt_r + CNT_W'(1);
          ok_nxt      = 1'b1;
        end
      end
      bdq_pkg::OP_INS_REAR: begin
        if (!full_now) begin
          tail_nxt    = wrap_inc(tail_r);
          mem_wr_addr = tail_r;
          mem_we      = acc;
          cnt_nxt     = cnt_r + CNT_W'(1);
          ok_nxt      = 1'b1;
        end
      end
      bdq_pkg::OP_DEL_FRONT: begin
        if (!empty_now) begin
          head_nxt = wrap_inc(head_r);
          cnt_nxt  = cnt_r - CNT_W'(1);
          ok_nxt   = 1'b1;
        end
      end
      bdq_pkg::OP_DEL_REAR: begin
        if (!empty_now) begin
          tail_nxt = wrap_dec(tail_r);
          cnt_nxt  = cnt_r - CNT_W'(1);
          ok_nxt   = 1'b1;
        end
      end
      bdq_pkg::OP_QUERY: begin
        ok_nxt = 1'b1;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
    full_nxt = CMP_W'(cnt_nxt) >= eff_cap;
  end

  // Sequencer: accept, read both ends, then hold the result word.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
      cap_r   <= bdq_pkg::CAP_RESET;
      ok_r    <= 1'b0;
      full_r  <= 1'b0;
      empty_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (acc) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        cnt_r   <= cnt_nxt;
        ok_r    <= ok_nxt;
        full_r  <= full_nxt;
        empty_r <= (cnt_nxt == '0);
      end
    end
  end

  // Ring memory write port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_wr_addr] <= in_data.item_value;
    end
  end

  // Ring memory read ports for the front and rear items after the update.
  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      rd_front_r <= ring_mem[head_r];
      rd_rear_r  <= ring_mem[wrap_dec(tail_r)];
    end
  end

  // Result word.
  always_comb begin
    out_data.success    = ok_r;
    out_data.front_item = empty_r ? bdq_pkg::EMPTY_ITEM : rd_front_r;
    out_data.rear_item  = empty_r ? bdq_pkg::EMPTY_ITEM : rd_rear_r;
    out_data.is_empty   = empty_r;
    out_data.is_full    = full_r;
  end

  // Checks on the queue's own bookkeeping.
  `BDQ_ASSERT_NOW(a_cnt_bound, 1'b1, CMP_W'(cnt_r) <= DEPTH_C, "item count above depth")
  `BDQ_ASSERT_NOW(a_empty_ptrs, cnt_r == '0, head_r == tail_r, "empty queue with split pointers")
  `BDQ_ASSERT_NOW(a_one_side, in_ready, !out_valid, "input open while result pending")
  `BDQ_ASSERT_NEXT(a_acc_read, acc, state_r == S_READ, "accepted word not followed by read")
  `BDQ_ASSERT_NEXT(a_refused_hold, acc && !ok_nxt, cnt_r == $past(cnt_r), "refused op changed count")

endmodule

FILE: tb/bounded_double_ended_queue_test.sv
// Self-checking testbench for the bounded double-ended queue.
module bounded_double_ended_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  // Opcodes that the block has to treat as unknown.
  localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 103;
  localparam int SETTLE_CYCLES = 8;
  localparam int TIMEOUT_NS    = 4_000_000;

  // Predicts each result word of the queue and checks what comes out.
  class deque_checker;
    localparam int SLOTS = DEPTH_DEFAULT;
    typedef logic [$clog2(SLOTS)-1:0] slot_t;

    logic [DATA_W-1:0] ring [SLOTS];
    slot_t             head;
    slot_t             tail;
    logic [CAP_W-1:0]  count;
    logic [CAP_W-1:0]  capacity;
    out_word_t         expected_words[$];
    int                mismatches;
    int                words;
    int                refused_inserts;
    int                refused_deletes;
    int                unknown_ops;
    int                full_results;

    function new();
      head     = '0;
      tail     = '0;
      count    = '0;
      capacity = CAP_RESET;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Apply one accepted word to the shadow queue and queue up its result.
    function void note_word(in_word_t w);
      out_word_t        want;
      logic [CAP_W-1:0] limit;
      logic             full;
      logic             empty;
      limit = (capacity > CAP_W'(SLOTS)) ? CAP_W'(SLOTS) : capacity;
      full  = count >= limit;
      empty = count == '0;
      want.success = 1'b0;
      case (w.opcode)
        OP_INS_FRONT: begin
          if (!full) begin
            head = head - slot_t'(1);
            ring[head] = w.item_value;
            count++;
            want.success = 1'b1;
          end else begin
            refused_inserts++;
          end
        end
        OP_INS_REAR: begin
          if (!full) begin
            ring[tail] = w.item_value;
            tail = tail + slot_t'(1);
            count++;
            want.success = 1'b1;
          end else begin
            refused_inserts++;
          end
        end
        OP_DEL_FRONT: begin
          if (!empty) begin
            head = head + slot_t'(1);
            count--;
            want.success = 1'b1;
          end else begin
            refused_deletes++;
          end
        end
        OP_DEL_REAR: begin
          if (!empty) begin
            tail = tail - slot_t'(1);
            count--;
            want.success = 1'b1;
          end else begin
            refused_deletes++;
          end
        end
        OP_QUERY: begin
          want.success = 1'b1;
        end
        default: begin
          unknown_ops++;
        end
      endcase
      // Only live entries are looked at, so unwritten slots are never read.
      if (count == '0) begin
        want.front_item = EMPTY_ITEM;
        want.rear_item  = EMPTY_ITEM;
      end else begin
        want.front_item = ring[head];
        want.rear_item  = ring[tail - slot_t'(1)];
      end
      want.is_empty = count == '0;
      want.is_full  = count >= limit;
      if (want.is_full) full_results++;
      words++;
      expected_words = {expected_words, want};
    endfunction

    // Compare a result word with the oldest prediction.
    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result word with nothing expected: %h", $realtime, got);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      if (got.success !== want.success || got.front_item !== want.front_item ||
          got.rear_item !== want.rear_item || got.is_empty !== want.is_empty ||
          got.is_full !== want.is_full) begin
        if (mismatches < 10) begin
          $display("%0t: mismatch  ok/front/rear/empty/full", $realtime);
          $display("  expected %b %h %h %b %b", want.success, want.front_item,
                   want.rear_item, want.is_empty, want.is_full);
          $display("  actual   %b %h %h %b %b", got.success, got.front_item,
                   got.rear_item, got.is_empty, got.is_full);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_word_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_data;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  deque_checker checker_h = new();
  int           max_stall = 0;
  int           max_gap = 0;
  int           ready_hold = 0;
  int           capacity_writes = 0;

  bounded_double_ended_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watch both handshakes and drive the receiver's stall pattern.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) checker_h.note_word(in_data);
      if (out_valid && out_ready) checker_h.check_word(out_data);
    end
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready && max_stall != 0) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, max_stall - 1);
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 7);
    end
  end

  // Present one word and hold it until the block takes it.
  task automatic send_word(logic [OP_W-1:0] op, logic [DATA_W-1:0] value);
    in_word_t w;
    w.opcode     = op;
    w.item_value = value;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (checker_h.pending() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    checker_h.capacity = value;
    capacity_writes++;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Insert-heavy or delete-heavy choice, with a few queries and unknown codes.
  function automatic logic [OP_W-1:0] pick_op(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (r >= 96) begin
      case ($urandom_range(0, 2))
        0: return OP_UNUSED_LO;
        1: return OP_UNUSED_MID;
        default: return OP_UNUSED_HI;
      endcase
    end
    if (r >= 92) return OP_QUERY;
    if (filling) begin
      if (r < 42) return OP_INS_FRONT;
      if (r < 84) return OP_INS_REAR;
      if (r < 88) return OP_DEL_FRONT;
      return OP_DEL_REAR;
    end
    if (r < 4) return OP_INS_FRONT;
    if (r < 8) return OP_INS_REAR;
    if (r < 50) return OP_DEL_FRONT;
    return OP_DEL_REAR;
  endfunction

  // Random words in bursts, swinging between filling and draining the queue.
  task automatic run_random(int count);
    int burst_left;
    int gap;
    int mode_left;
    bit filling;
    burst_left = 0;
    mode_left  = 0;
    filling    = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, max_gap);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      if (mode_left == 0) begin
        filling   = !filling;
        mode_left = $urandom_range(4, 30);
      end
      mode_left--;
      send_word(pick_op(filling), pick_value());
    end
  endtask

  initial begin
    int caps [RANDOM_PHASES];
    int stalls [RANDOM_PHASES];
    int gaps [RANDOM_PHASES];
    caps   = '{16, 5, 31, 1, 0, 17, 8, 0};
    stalls = '{0, 3, 10, 0, 3, 10, 2, 6};
    gaps   = '{0, 2, 6, 4, 0, 6, 1, 3};
    caps[RANDOM_PHASES-1] = $urandom_range(0, 31);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue at the reset capacity, extreme values, unknown codes.
    send_word(OP_QUERY, 32'h0000_0000);
    send_word(OP_DEL_FRONT, 32'h1234_5678);
    send_word(OP_DEL_REAR, 32'h8765_4321);
    send_word(OP_UNUSED_LO, 32'hdead_beef);
    send_word(OP_INS_FRONT, 32'h7fff_ffff);
    send_word(OP_INS_REAR, 32'h8000_0000);
    send_word(OP_INS_FRONT, 32'hffff_ffff);
    send_word(OP_INS_REAR, 32'h0000_0000);
    send_word(OP_UNUSED_MID, 32'h0f0f_0f0f);
    send_word(OP_DEL_FRONT, 32'h0000_0000);
    send_word(OP_DEL_REAR, 32'h0000_0000);
    send_word(OP_UNUSED_HI, 32'hf0f0_f0f0);
    send_word(OP_QUERY, 32'hffff_ffff);

    // Two items held at capacity two: the first two inserts are refused.
    write_capacity(5'd2);
    send_word(OP_INS_FRONT, 32'h1111_1111);
    send_word(OP_INS_REAR, 32'h2222_2222);
    send_word(OP_DEL_REAR, 32'h0000_0000);
    send_word(OP_INS_FRONT, 32'h5555_aaaa);
    send_word(OP_QUERY, 32'h0000_0000);

    // Capacity zero: items stay, inserts are refused, deletes still work.
    write_capacity(5'd0);
    send_word(OP_INS_REAR, 32'haaaa_5555);
    send_word(OP_DEL_FRONT, 32'h0000_0000);
    send_word(OP_DEL_FRONT, 32'h0000_0000);
    send_word(OP_DEL_FRONT, 32'h0000_0000);
    send_word(OP_INS_FRONT, 32'h7fff_ffff);

    // Random phases over several capacities, some lowered under the count.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_capacity(CAP_W'(caps[p]));
      max_stall = stalls[p];
      max_gap   = gaps[p];
      run_random(PHASE_WORDS);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d queue words under %0d capacity writes, extremes and unknown codes.",
             checker_h.words, capacity_writes);
    $display("Refused %0d inserts and %0d deletes; %0d unknown codes; %0d full results.",
             checker_h.refused_inserts, checker_h.refused_deletes,
             checker_h.unknown_ops, checker_h.full_results);
    if (checker_h.mismatches == 0 && checker_h.pending() == 0) begin
      $display("PASS bounded_double_ended_queue");
    end else begin
      $display("%0d mismatches", checker_h.mismatches);
      $display("FAIL bounded_double_ended_queue");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d results outstanding", checker_h.pending());
    $display("FAIL bounded_double_ended_queue");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/bdq_pkg.sv
src/bounded_double_ended_queue.sv
tb/bounded_double_ended_queue_test.sv
